>>> hw/rtl/owsm_pkg.sv
// Shared types, widths, constants and helpers of the omni wheel speed mixer.
package owsm_pkg;

	localparam int TRIG_FRACTION_BITS = 14;

	localparam int IN_W    = 11;
	localparam int DZ_W    = 10;
	localparam int GAIN_W  = 12;
	localparam int SPD_W   = 10;
	localparam int CFG_W   = 12;
	localparam int CIDX_W  = 2;
	localparam int OUT_W   = 16;
	localparam int SPIN_W  = 16;

	localparam int SQ_W    = 2 * IN_W;
	localparam int R2_W    = 2 * IN_W;
	localparam int RAD_W   = R2_W + 16;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int RREM_W  = ROOT_W + 2;

	localparam int COEF_W  = TRIG_FRACTION_BITS + 12;
	localparam int PROD_W  = COEF_W + 11;
	localparam int NORM_SH = TRIG_FRACTION_BITS - 8;
	localparam int HALF_SH = TRIG_FRACTION_BITS - 1;
	localparam int ONE_SH  = TRIG_FRACTION_BITS;

	localparam int DIV_NUM_W = 30;
	localparam int DIV_DEN_W = ROOT_W;

	localparam int TRANS_W = 13;
	localparam int WHEEL_W = 17;
	localparam int NUM_W   = 17;
	localparam int PROD2_W = 30;
	localparam int FQ_W    = 29;

	localparam int WHEELS  = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	function automatic longint isqrt_const(input longint v);
		longint rem_v;
		longint res_v;
		longint bit_v;
		rem_v = v;
		res_v = 0;
		bit_v = longint'(1) << 62;
		while (bit_v > rem_v)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (rem_v >= res_v + bit_v) begin
				rem_v = rem_v - (res_v + bit_v);
				res_v = (res_v >> 1) + bit_v;
			end else begin
				res_v = res_v >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res_v;
	endfunction

	localparam longint TRIG_K_L =
		(isqrt_const(longint'(3) << (2 * TRIG_FRACTION_BITS)) + 1) >> 1;
	localparam logic signed [COEF_W-1:0] TRIG_K = COEF_W'(TRIG_K_L);

	typedef enum logic [CIDX_W-1:0] {
		CFG_DZ_LIMIT,
		CFG_ROT_GAIN,
		CFG_SPEED_FLOOR,
		CFG_SPEED_CEILING
	} cfg_idx_e;

	typedef struct packed {
		logic [DZ_W-1:0]   dz_limit;
		logic [GAIN_W-1:0] rot_gain;
		logic [SPD_W-1:0]  speed_floor;
		logic [SPD_W-1:0]  speed_ceiling;
	} cfg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_l;
		logic signed [COEF_W-1:0] coef_r;
		logic signed [COEF_W-1:0] coef_t;
		logic signed [SPIN_W-1:0] spin;
	} sq_side_t;

	typedef struct packed {
		logic [R2_W-1:0] r2;
		sq_side_t        side;
	} item_t;

	typedef struct packed {
		logic                      neg;
		logic                      rescale;
		logic signed [WHEEL_W-1:0] wheel;
		logic signed [SPIN_W-1:0]  spin;
	} lane_t;

	function automatic logic signed [OUT_W-1:0] sat16(input logic signed [31:0] v);
		if (v > SAT_MAX)
			return OUT_W'(SAT_MAX);
		if (v < SAT_MIN)
			return OUT_W'(SAT_MIN);
		return v[OUT_W-1:0];
	endfunction

endpackage

>>> hw/rtl/owsm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module owsm_div import owsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [DIV_NUM_W-1:0] in_num,
	input  logic [DIV_DEN_W-1:0] in_den,
	input  lane_t                in_side,
	output logic                 out_valid,
	output logic [DIV_NUM_W-1:0] out_quo,
	output logic                 out_rem_nz,
	output lane_t                out_side
);
	localparam int STEPS = DIV_NUM_W;

	logic [STEPS-1:0]     vld_q;
	logic [DIV_DEN_W-1:0] rem_q [STEPS];
	logic [DIV_NUM_W-1:0] num_q [STEPS];
	logic [DIV_NUM_W-1:0] quo_q [STEPS];
	logic [DIV_DEN_W-1:0] den_q [STEPS];
	lane_t                side_q [STEPS];

	logic [DIV_DEN_W-1:0] cur_rem [STEPS];
	logic [DIV_NUM_W-1:0] cur_num [STEPS];
	logic [DIV_NUM_W-1:0] cur_quo [STEPS];
	logic [DIV_DEN_W-1:0] cur_den [STEPS];
	lane_t                cur_side [STEPS];
	logic [DIV_DEN_W-1:0] rem_d [STEPS];
	logic [DIV_NUM_W-1:0] quo_d [STEPS];

	always_comb begin
		cur_rem[0]  = '0;
		cur_num[0]  = in_num;
		cur_quo[0]  = '0;
		cur_den[0]  = in_den;
		cur_side[0] = in_side;
		for (int i = 1; i < STEPS; i++) begin
			cur_rem[i]  = rem_q[i-1];
			cur_num[i]  = num_q[i-1];
			cur_quo[i]  = quo_q[i-1];
			cur_den[i]  = den_q[i-1];
			cur_side[i] = side_q[i-1];
		end
	end

	always_comb begin
		logic [DIV_DEN_W:0] t;
		logic [DIV_DEN_W:0] diff;
		logic               ge;
		for (int i = 0; i < STEPS; i++) begin
			t        = {cur_rem[i], cur_num[i][DIV_NUM_W-1]};
			diff     = t - {1'b0, cur_den[i]};
			ge       = (t >= {1'b0, cur_den[i]});
			rem_d[i] = ge ? diff[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
			quo_d[i] = {cur_quo[i][DIV_NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STEPS; i++) begin
			rem_q[i]  <= rem_d[i];
			num_q[i]  <= cur_num[i] << 1;
			quo_q[i]  <= quo_d[i];
			den_q[i]  <= cur_den[i];
			side_q[i] <= cur_side[i];
		end
	end

	assign out_valid  = vld_q[STEPS-1];
	assign out_quo    = quo_q[STEPS-1];
	assign out_rem_nz = (rem_q[STEPS-1] != '0);
	assign out_side   = side_q[STEPS-1];

endmodule

>>> hw/rtl/owsm_sqrt.sv
// Pipelined integer square root, one root bit per stage, with side data.
module owsm_sqrt import owsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  in_rad,
	input  sq_side_t          in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output sq_side_t          out_side
);
	localparam int STEPS = ROOT_W;

	logic [STEPS-1:0]  vld_q;
	logic [RREM_W-1:0] rem_q [STEPS];
	logic [RAD_W-1:0]  rad_q [STEPS];
	logic [ROOT_W-1:0] root_q [STEPS];
	sq_side_t          side_q [STEPS];

	logic [RREM_W-1:0] cur_rem [STEPS];
	logic [RAD_W-1:0]  cur_rad [STEPS];
	logic [ROOT_W-1:0] cur_root [STEPS];
	sq_side_t          cur_side [STEPS];
	logic [RREM_W-1:0] rem_d [STEPS];
	logic [ROOT_W-1:0] root_d [STEPS];

	always_comb begin
		cur_rem[0]  = '0;
		cur_rad[0]  = in_rad;
		cur_root[0] = '0;
		cur_side[0] = in_side;
		for (int i = 1; i < STEPS; i++) begin
			cur_rem[i]  = rem_q[i-1];
			cur_rad[i]  = rad_q[i-1];
			cur_root[i] = root_q[i-1];
			cur_side[i] = side_q[i-1];
		end
	end

	always_comb begin
		logic [RREM_W+1:0] t;
		logic [RREM_W+1:0] trial;
		logic [RREM_W+1:0] diff;
		logic              ge;
		for (int i = 0; i < STEPS; i++) begin
			t         = {cur_rem[i], cur_rad[i][RAD_W-1 -: 2]};
			trial     = (RREM_W + 2)'({cur_root[i], 2'b01});
			diff      = t - trial;
			ge        = (t >= trial);
			rem_d[i]  = ge ? diff[RREM_W-1:0] : t[RREM_W-1:0];
			root_d[i] = {cur_root[i][ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STEPS; i++) begin
			rem_q[i]  <= rem_d[i];
			rad_q[i]  <= cur_rad[i] << 2;
			root_q[i] <= root_d[i];
			side_q[i] <= cur_side[i];
		end
	end

	assign out_valid = vld_q[STEPS-1];
	assign out_root  = root_q[STEPS-1];
	assign out_side  = side_q[STEPS-1];

endmodule

>>> hw/rtl/owsm_front.sv
// Front end: command capture, dead zone, spin gain and projection numerators.
module owsm_front import owsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	input  logic signed [IN_W-1:0] x_command,
	input  logic signed [IN_W-1:0] y_command,
	input  logic signed [IN_W-1:0] spin_command,
	output logic                   out_valid,
	output item_t                  out_item
);
	localparam int GP_W = IN_W + GAIN_W + 1;

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [IN_W-1:0]    x_s1, y_s1, sp_s1;
	logic signed [IN_W-1:0]    x_s2, y_s2, sp_s2;
	logic [SQ_W-2:0]           xx_s3, yy_s3;
	logic signed [COEF_W-1:0]  kx_s3;
	logic signed [IN_W-1:0]    y_s3;
	logic signed [GP_W-1:0]    p_s3;
	logic                      zero_s3;
	item_t                     item_s4;

	logic signed [SQ_W-1:0]    x_sq, y_sq, xx_w, yy_w;
	logic signed [COEF_W-1:0]  x_c, y_c, kx_w, hy_w, uy_w;
	logic signed [GP_W-1:0]    sp_e, g_e, p_w, p_adj;
	item_t                     item_d;

	function automatic logic signed [IN_W-1:0] dz(input logic signed [IN_W-1:0] v,
		input logic [DZ_W-1:0] lim);
		logic [IN_W-1:0] a;
		a = v[IN_W-1] ? -v : v;
		return (a < {1'b0, lim}) ? '0 : v;
	endfunction

	always_comb begin
		x_sq = SQ_W'(x_s2);
		y_sq = SQ_W'(y_s2);
		xx_w = x_sq * x_sq;
		yy_w = y_sq * y_sq;
		x_c  = COEF_W'(x_s2);
		kx_w = x_c * TRIG_K;
		sp_e = GP_W'(sp_s2);
		g_e  = GP_W'({1'b0, cfg.rot_gain});
		p_w  = sp_e * g_e;
	end

	always_comb begin
		y_c   = COEF_W'(y_s3);
		hy_w  = y_c <<< HALF_SH;
		uy_w  = y_c <<< ONE_SH;
		p_adj = p_s3 + $signed({{(GP_W-8){1'b0}}, {8{p_s3[GP_W-1]}}});
		item_d.r2 = R2_W'({1'b0, xx_s3}) + R2_W'({1'b0, yy_s3});
		item_d.side.spin = p_adj[SPIN_W+7:8];
		if (zero_s3) begin
			item_d.side.coef_l = -TRIG_K;
			item_d.side.coef_r = TRIG_K;
			item_d.side.coef_t = '0;
		end else begin
			item_d.side.coef_l = hy_w - kx_s3;
			item_d.side.coef_r = hy_w + kx_s3;
			item_d.side.coef_t = -uy_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			x_s1  <= x_command;
			y_s1  <= y_command;
			sp_s1 <= spin_command;
		end
		x_s2    <= dz(x_s1, cfg.dz_limit);
		y_s2    <= dz(y_s1, cfg.dz_limit);
		sp_s2   <= dz(sp_s1, cfg.dz_limit);
		xx_s3   <= xx_w[SQ_W-2:0];
		yy_s3   <= yy_w[SQ_W-2:0];
		kx_s3   <= kx_w;
		y_s3    <= y_s2;
		p_s3    <= p_w;
		zero_s3 <= (x_s2 == '0) && (y_s2 == '0);
		item_s4 <= item_d;
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;

endmodule

>>> hw/rtl/owsm_queue.sv
// Short queue between the front end and the back end.
module owsm_queue import owsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  out_valid,
	output item_t out_item,
	output logic  full
);
	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign out_valid = (cnt_q != '0);
	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign out_item  = mem_q[rd_q];
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

>>> hw/rtl/owsm_back.sv
// Back end: speed clamp, wheel projection, ceiling rescale and saturation.
module owsm_back import owsm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	input  item_t                   in_item,
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] left_speed,
	output logic signed [OUT_W-1:0] right_speed,
	output logic signed [OUT_W-1:0] tail_speed
);
	logic                     sq_valid;
	logic [ROOT_W-1:0]        sq_root;
	sq_side_t                 sq_side;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, done_q;
	logic signed [PROD_W-1:0] n_s1 [WHEELS];
	logic [DIV_DEN_W-1:0]     rq_s1, rq_s2;
	logic signed [SPIN_W-1:0] spin_s1, spin_s3, spin_s4;
	logic [DIV_NUM_W-1:0]     mag_s2 [WHEELS];
	lane_t                    lane_s2 [WHEELS];
	logic signed [TRANS_W-1:0] trans_s3 [WHEELS];
	logic signed [PROD2_W-1:0] prod_s4 [WHEELS];
	logic signed [WHEEL_W-1:0] w_s4 [WHEELS];
	logic [DIV_DEN_W-1:0]     d_s4, d_s5;
	logic                     resc_s4;
	logic [DIV_NUM_W-1:0]     mag_s5 [WHEELS];
	lane_t                    lane_s5 [WHEELS];
	logic signed [OUT_W-1:0]  res_q [WHEELS];

	logic [WHEELS-1:0]        d1_valid, d2_valid;
	logic [DIV_NUM_W-1:0]     d1_quo [WHEELS];
	logic [DIV_NUM_W-1:0]     d2_quo [WHEELS];
	logic [WHEELS-1:0]        d2_rnz;
	lane_t                    d1_side [WHEELS];
	lane_t                    d2_side [WHEELS];

	logic [ROOT_W-1:0]        rq_w;
	logic [ROOT_W-9:0]        sp_raw, sp_lo, sp_cl;
	logic signed [PROD_W-1:0] spd_x;
	logic signed [PROD_W-1:0] coef_x [WHEELS];
	logic signed [PROD_W-1:0] n_w [WHEELS];
	logic [PROD_W-1:0]        absn [WHEELS];
	logic [PROD_W-1:0]        shn [WHEELS];
	logic signed [TRANS_W-1:0] tq [WHEELS];
	logic signed [TRANS_W-1:0] trans_w [WHEELS];
	logic signed [WHEEL_W-1:0] w_w [WHEELS];
	logic signed [WHEEL_W-1:0] mx_w, ceil_w;
	logic signed [TRANS_W-1:0] d_w;
	logic signed [NUM_W-1:0]  num_w;
	logic signed [PROD2_W-1:0] num_x;
	logic signed [PROD2_W-1:0] tr_x [WHEELS];
	logic signed [PROD2_W-1:0] prod_w [WHEELS];
	logic [PROD2_W-1:0]       absp [WHEELS];
	logic signed [FQ_W-1:0]   qe [WHEELS];
	logic signed [FQ_W-1:0]   rnz_x [WHEELS];
	logic signed [FQ_W-1:0]   fq [WHEELS];
	logic signed [FQ_W-1:0]   res_w [WHEELS];

	owsm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_rad    ({in_item.r2, 16'b0}),
		.in_side   (in_item.side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	always_comb begin
		rq_w   = (sq_root == '0) ? ROOT_W'(256) : sq_root;
		sp_raw = sq_root[ROOT_W-1:8];
		sp_lo  = (sp_raw < (ROOT_W-8)'(cfg.speed_floor)) ? (ROOT_W-8)'(cfg.speed_floor) : sp_raw;
		sp_cl  = (sp_lo > (ROOT_W-8)'(cfg.speed_ceiling)) ? (ROOT_W-8)'(cfg.speed_ceiling)
			: sp_lo;
		spd_x  = $signed({{(PROD_W-ROOT_W+8){1'b0}}, sp_cl});
		coef_x[0] = PROD_W'(sq_side.coef_l);
		coef_x[1] = PROD_W'(sq_side.coef_r);
		coef_x[2] = PROD_W'(sq_side.coef_t);
		for (int i = 0; i < WHEELS; i++) begin
			n_w[i]  = spd_x * coef_x[i];
			absn[i] = n_s1[i][PROD_W-1] ? -n_s1[i] : n_s1[i];
			shn[i]  = absn[i] >> NORM_SH;
		end
	end

	generate
		for (genvar w = 0; w < WHEELS; w++) begin : g_div1
			owsm_div u_div (
				.clk        (clk),
				.arst_n     (arst_n),
				.in_valid   (v_s2),
				.in_num     (mag_s2[w]),
				.in_den     (rq_s2),
				.in_side    (lane_s2[w]),
				.out_valid  (d1_valid[w]),
				.out_quo    (d1_quo[w]),
				.out_rem_nz (),
				.out_side   (d1_side[w])
			);
		end
	endgenerate

	always_comb begin
		ceil_w = $signed({{(WHEEL_W-SPD_W){1'b0}}, cfg.speed_ceiling});
		for (int i = 0; i < WHEELS; i++) begin
			tq[i]      = $signed({1'b0, d1_quo[i][TRANS_W-2:0]});
			trans_w[i] = d1_side[i].neg ? -tq[i] : tq[i];
			w_w[i]     = WHEEL_W'(trans_s3[i]) + WHEEL_W'(spin_s3);
		end
		mx_w = w_w[0];
		d_w  = trans_s3[0];
		for (int i = 1; i < WHEELS; i++) begin
			if (w_w[i] > mx_w)
				mx_w = w_w[i];
			if (trans_s3[i] > d_w)
				d_w = trans_s3[i];
		end
		num_w = NUM_W'(ceil_w) - NUM_W'(spin_s3);
		num_x = PROD2_W'(num_w);
		for (int i = 0; i < WHEELS; i++) begin
			tr_x[i]   = PROD2_W'(trans_s3[i]);
			prod_w[i] = tr_x[i] * num_x;
			absp[i]   = prod_s4[i][PROD2_W-1] ? -prod_s4[i] : prod_s4[i];
		end
	end

	generate
		for (genvar w = 0; w < WHEELS; w++) begin : g_div2
			owsm_div u_div (
				.clk        (clk),
				.arst_n     (arst_n),
				.in_valid   (v_s5),
				.in_num     (mag_s5[w]),
				.in_den     (d_s5),
				.in_side    (lane_s5[w]),
				.out_valid  (d2_valid[w]),
				.out_quo    (d2_quo[w]),
				.out_rem_nz (d2_rnz[w]),
				.out_side   (d2_side[w])
			);
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < WHEELS; i++) begin
			qe[i]    = $signed({2'b00, d2_quo[i][FQ_W-3:0]});
			rnz_x[i] = $signed({{(FQ_W-1){1'b0}}, d2_rnz[i]});
			fq[i]    = d2_side[i].neg ? -(qe[i] + rnz_x[i]) : qe[i];
			res_w[i] = d2_side[i].rescale ? fq[i] + FQ_W'(d2_side[i].spin)
				: FQ_W'(d2_side[i].wheel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= sq_valid;
			v_s2   <= v_s1;
			v_s3   <= &d1_valid;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= &d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		rq_s1   <= rq_w;
		spin_s1 <= sq_side.spin;
		rq_s2   <= rq_s1;
		spin_s3 <= d1_side[0].spin;
		spin_s4 <= spin_s3;
		d_s4    <= DIV_DEN_W'(d_w[TRANS_W-2:0]);
		resc_s4 <= (mx_w > ceil_w) && (d_w != '0);
		d_s5    <= d_s4;
		for (int i = 0; i < WHEELS; i++) begin
			n_s1[i]            <= n_w[i];
			mag_s2[i]          <= shn[i][DIV_NUM_W-1:0];
			lane_s2[i].neg     <= n_s1[i][PROD_W-1];
			lane_s2[i].rescale <= 1'b0;
			lane_s2[i].wheel   <= '0;
			lane_s2[i].spin    <= spin_s1;
			trans_s3[i]        <= trans_w[i];
			prod_s4[i]         <= prod_w[i];
			w_s4[i]            <= w_w[i];
			mag_s5[i]          <= absp[i][DIV_NUM_W-1:0];
			lane_s5[i].neg     <= prod_s4[i][PROD2_W-1];
			lane_s5[i].rescale <= resc_s4;
			lane_s5[i].wheel   <= w_s4[i];
			lane_s5[i].spin    <= spin_s4;
			res_q[i]           <= sat16(32'(res_w[i]));
		end
	end

	assign out_valid   = done_q;
	assign left_speed  = res_q[0];
	assign right_speed = res_q[1];
	assign tail_speed  = res_q[2];

endmodule

>>> hw/rtl/omni_wheel_speed_mixer_unit.sv
// Top level of the three-wheel omni drive speed mixer.
// Takes one body command (x, y, spin) per clock whenever busy is low and
// gives the three wheel speeds for it with done high for exactly one
// cycle; results cannot be held off, so capture them on done. The path
// holds the 19-step square root and the two 30-step dividers (projection
// and ceiling rescale), all fully pipelined, so the sustained rate is one
// command per cycle while busy is low. Write the configuration registers
// only while no command is in flight.
module omni_wheel_speed_mixer_unit import owsm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  x_command,
	input  logic signed [IN_W-1:0]  y_command,
	input  logic signed [IN_W-1:0]  spin_command,
	output logic                    done,
	output logic signed [OUT_W-1:0] left_speed,
	output logic signed [OUT_W-1:0] right_speed,
	output logic signed [OUT_W-1:0] tail_speed,
	input  logic                    cfg_write,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);
	cfg_t  cfg_q;
	logic  accept;
	logic  fr_valid, q_valid, q_full;
	item_t fr_item, q_item;

	assign accept = start && !busy;
	assign busy   = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dz_limit      <= DZ_W'(10);
			cfg_q.rot_gain      <= GAIN_W'(256);
			cfg_q.speed_floor   <= '0;
			cfg_q.speed_ceiling <= SPD_W'(100);
		end else if (cfg_write) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_DZ_LIMIT:      cfg_q.dz_limit      <= cfg_data[DZ_W-1:0];
				CFG_ROT_GAIN:      cfg_q.rot_gain      <= cfg_data[GAIN_W-1:0];
				CFG_SPEED_FLOOR:   cfg_q.speed_floor   <= cfg_data[SPD_W-1:0];
				CFG_SPEED_CEILING: cfg_q.speed_ceiling <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	owsm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (accept),
		.x_command    (x_command),
		.y_command    (y_command),
		.spin_command (spin_command),
		.out_valid    (fr_valid),
		.out_item     (fr_item)
	);

	owsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid),
		.push_item (fr_item),
		.pop       (q_valid),
		.out_valid (q_valid),
		.out_item  (q_item),
		.full      (q_full)
	);

	owsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (q_valid),
		.in_item     (q_item),
		.out_valid   (done),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.tail_speed  (tail_speed)
	);

endmodule
